// File: rtl/sparse_context_bit_predictor_assert.svh
// assertion macros for the sparse context bit predictor
`ifndef SPARSE_CONTEXT_BIT_PREDICTOR_ASSERT_SVH
`define SPARSE_CONTEXT_BIT_PREDICTOR_ASSERT_SVH

// same-cycle implication
`define SCP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// File: rtl/scp_pkg.sv
package scp_pkg;

  localparam int WINDOW      = 4096;
  localparam int MODEL_COUNT = 8;
  localparam int CTX_BACK    = 3;
  localparam int AW          = $clog2(WINDOW);
  localparam int BS_W        = AW + 1;
  localparam int CNT_W       = AW;
  localparam int SHIFT_MAX   = 7;
  localparam int WT_W        = CNT_W + SHIFT_MAX;
  localparam int TOT_W       = 19;
  localparam int ACC_W       = WT_W + 4;
  localparam logic [ACC_W-1:0] TOTAL_MAX = ACC_W'(262155);
  localparam logic [9:0] BASE_RESET  = 10'd11;
  localparam logic [2:0] BOOST_RESET = 3'd3;

  typedef struct packed {
    logic       clr;
    logic       upd;
    logic       p;
    logic [2:0] eq;
    logic [2:0] sel;
  } scp_ctl_t;

endpackage

// File: rtl/scp_ifs.sv
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic        actual_bit;
  logic [2:0]  bit_index;
  logic [18:0] zero_total;
  logic [18:0] one_total;
  logic        last_of_byte;
  modport source (output valid, actual_bit, bit_index, zero_total, one_total, last_of_byte,
                  input ready);
  modport sink (input valid, actual_bit, bit_index, zero_total, one_total, last_of_byte,
                output ready);
endinterface

// File: rtl/scp_hist_ram.sv
module scp_hist_ram #(
  parameter int DW = 8,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/scp_lanes.sv
module scp_lanes (
  input  logic                     clk,
  input  logic                     rst,
  input  scp_pkg::scp_ctl_t        ctl,
  input  logic [2:0]               boost_shift,
  output logic [scp_pkg::WT_W-1:0] w0,
  output logic [scp_pkg::WT_W-1:0] w1
);
  logic [scp_pkg::CNT_W-1:0] c0 [scp_pkg::MODEL_COUNT];
  logic [scp_pkg::CNT_W-1:0] c1 [scp_pkg::MODEL_COUNT];
  logic [scp_pkg::CNT_W-1:0] s0, s1;
  logic [2:0]                sh;

  for (genvar m = 0; m < scp_pkg::MODEL_COUNT; m++) begin : g_lane
    localparam logic [2:0] MB = 3'(m);
    logic match;
    assign match = &(~MB | ctl.eq);
    always_ff @(posedge clk) begin
      if (rst || ctl.clr) begin
        c0[m] <= '0;
        c1[m] <= '0;
      end else if (ctl.upd && match) begin
        if (ctl.p) begin
          c1[m] <= c1[m] + 1'b1;
          if (c0[m] > scp_pkg::CNT_W'(1)) c0[m] <= c0[m] >> 1;
        end else begin
          c0[m] <= c0[m] + 1'b1;
          if (c1[m] > scp_pkg::CNT_W'(1)) c1[m] <= c1[m] >> 1;
        end
      end
    end
  end

  // weighted counts of one model per cycle
  always_comb begin
    s0 = c0[ctl.sel];
    s1 = c1[ctl.sel];
    sh = (s0 == '0 || s1 == '0) ? boost_shift : 3'd0;
  end

  always_ff @(posedge clk) begin
    w0 <= scp_pkg::WT_W'(s0) << sh;
    w1 <= scp_pkg::WT_W'(s1) << sh;
  end
endmodule

// File: rtl/sparse_context_bit_predictor.sv
// sequence: per bit min(bytes_seen, 4093) + 3 history reads, one per cycle on the history
//   ram port, then a wait state, the model weight sums and the output register; the
//   result side can stall each bit in the output state
// input: a new byte is accepted only when idle, after the last bit of the previous byte
//   has been loaded into the output register
// reset: synchronous, history treated as empty through a fill count, no clearing pass;
//   base_count returns to 11 and boost_shift to 3
`include "sparse_context_bit_predictor_assert.svh"

module sparse_context_bit_predictor (
  input  logic              clk,
  input  logic              rst,
  scp_in_if.sink            in_ch,
  scp_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [0:0] REG_BASE  = 1'b0;
  localparam logic [0:0] REG_BOOST = 1'b1;

  logic [2:0] state;

  // configuration registers
  logic [9:0] base_count;
  logic [2:0] boost_shift;

  // stream state: fill count, write pointer, three most recent bytes
  logic [scp_pkg::BS_W-1:0] bytes_seen;
  logic [scp_pkg::AW-1:0]   wp;
  logic [7:0]               cur_ctx [scp_pkg::CTX_BACK];

  // current byte transaction
  logic [7:0] cur;
  logic       last;
  logic [2:0] bitpos;

  // scan control
  logic [scp_pkg::BS_W-1:0] maxd;
  logic [scp_pkg::BS_W-1:0] back;
  logic                     rd_v, rd_proc, rd_zero;
  logic [7:0]               ram_q, hbyte;
  logic [7:0]               hctx [scp_pkg::CTX_BACK];
  logic [7:0]               mask;
  logic                     hit;

  // summing
  logic [3:0]                 k;
  logic [scp_pkg::ACC_W-1:0]  acc0, acc1;
  logic [scp_pkg::WT_W-1:0]   w0, w1;
  scp_pkg::scp_ctl_t          ctl;

  logic out_valid, load, wr;

  // apb: word decode on paddr[2]
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_BASE:  prdata = {22'd0, base_count};
      REG_BOOST: prdata = {29'd0, boost_shift};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count  <= scp_pkg::BASE_RESET;
      boost_shift <= scp_pkg::BOOST_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BASE) base_count <= pwdata[9:0];
      else boost_shift <= pwdata[2:0];
    end
  end

  // scan bound keeps every context byte of a scanned position in the window
  assign maxd = (bytes_seen > scp_pkg::BS_W'(scp_pkg::WINDOW - scp_pkg::CTX_BACK)) ?
                scp_pkg::BS_W'(scp_pkg::WINDOW - scp_pkg::CTX_BACK) : bytes_seen;

  assign in_ch.ready = (state == S_IDLE);
  assign load = (state == S_PUT) && (!out_valid || out_ch.ready);
  assign wr   = load && (bitpos == 3'd7) && !last;

  scp_hist_ram #(.DW(8), .AW(scp_pkg::AW)) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (wp),
    .wdata (cur),
    .raddr (wp - back[scp_pkg::AW-1:0]),
    .rdata (ram_q)
  );

  // positions beyond the fill count read as the pre-stream zero
  assign hbyte = rd_zero ? 8'd0 : ram_q;
  assign mask  = ~(8'hFF >> bitpos);
  assign hit   = rd_v && rd_proc && (((hbyte ^ cur) & mask) == 8'd0);

  always_comb begin
    ctl.clr = (state == S_IDLE) || (state == S_PUT);
    ctl.upd = hit;
    ctl.p   = hbyte[3'd7 - bitpos];
    for (int i = 0; i < scp_pkg::CTX_BACK; i++) ctl.eq[i] = (hctx[i] == cur_ctx[i]);
    ctl.sel = k[2:0];
  end

  scp_lanes u_lanes (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .boost_shift (boost_shift),
    .w0          (w0),
    .w1          (w1)
  );

  // read pipeline and context shift line of scanned bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN);
    end
    rd_proc <= (back <= maxd);
    rd_zero <= (back > bytes_seen);
    if (rd_v) begin
      hctx[2] <= hctx[1];
      hctx[1] <= hctx[0];
      hctx[0] <= hbyte;
    end
  end

  // main sequencer: per bit scan oldest first, then sum model weights
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bytes_seen <= '0;
      wp         <= '0;
      bitpos     <= '0;
      k          <= '0;
      for (int i = 0; i < scp_pkg::CTX_BACK; i++) cur_ctx[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur    <= in_ch.data_byte;
            last   <= in_ch.last_byte;
            bitpos <= '0;
            back   <= maxd + scp_pkg::BS_W'(scp_pkg::CTX_BACK);
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          back <= back - 1'b1;
          if (back == scp_pkg::BS_W'(1)) state <= S_WAIT;
        end
        S_WAIT: begin
          k     <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (k == 4'd0) begin
            acc0 <= scp_pkg::ACC_W'(base_count);
            acc1 <= scp_pkg::ACC_W'(base_count);
          end else begin
            acc0 <= acc0 + scp_pkg::ACC_W'(w0);
            acc1 <= acc1 + scp_pkg::ACC_W'(w1);
          end
          k <= k + 1'b1;
          if (k == 4'(scp_pkg::MODEL_COUNT)) state <= S_PUT;
        end
        S_PUT: begin
          if (load) begin
            bitpos <= bitpos + 1'b1;
            back   <= maxd + scp_pkg::BS_W'(scp_pkg::CTX_BACK);
            if (bitpos == 3'd7) begin
              state <= S_IDLE;
              if (last) begin
                bytes_seen <= '0;
                wp         <= '0;
                for (int i = 0; i < scp_pkg::CTX_BACK; i++) cur_ctx[i] <= '0;
              end else begin
                wp <= wp + 1'b1;
                if (bytes_seen < scp_pkg::BS_W'(scp_pkg::WINDOW))
                  bytes_seen <= bytes_seen + 1'b1;
                cur_ctx[2] <= cur_ctx[1];
                cur_ctx[1] <= cur_ctx[0];
                cur_ctx[0] <= cur;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_ch.actual_bit   <= cur[3'd7 - bitpos];
      out_ch.bit_index    <= bitpos;
      out_ch.zero_total   <= (acc0 > scp_pkg::TOTAL_MAX) ? scp_pkg::TOTAL_MAX[18:0] : acc0[18:0];
      out_ch.one_total    <= (acc1 > scp_pkg::TOTAL_MAX) ? scp_pkg::TOTAL_MAX[18:0] : acc1[18:0];
      out_ch.last_of_byte <= (bitpos == 3'd7);
    end
  end
  assign out_ch.valid = out_valid;

  `SCP_ASSERT_NEXT(a_accept_starts_scan, in_ch.valid && in_ch.ready, state == S_SCAN, "accept did not start scan")
  `SCP_ASSERT_NOW(a_no_read_idle, state == S_IDLE, !rd_v, "read pending while idle")
  `SCP_ASSERT_NEXT(a_byte_end_idle, load && (bitpos == 3'd7), state == S_IDLE && out_valid, "byte did not finish")
endmodule
